// File: sv/pidf_pkg.sv
`default_nettype none

package pidf_pkg;

   // Fixed stretches of the capture stream, in bytes.
   localparam logic [5:0] GLOBAL_LEN = 6'd24;
   localparam logic [5:0] RECHDR_LEN = 6'd16;
   localparam logic [5:0] LINK_LEN   = 6'd42;
   localparam logic [5:0] SEGHDR_LEN = 6'd40;

   localparam logic [31:0] NS_PER_SEC       = 32'd1000000000;
   localparam logic [9:0]  NS_PER_USEC      = 10'd1000;
   localparam logic [31:0] MAX_RECORDS_INIT = 32'd1000000000;

   localparam logic [7:0] CHAR_TRADE = 8'h54;   // 'T'
   localparam logic [7:0] CHAR_BID   = 8'h38;   // '8'
   localparam logic [7:0] CHAR_ASK   = 8'h35;   // '5'

   localparam logic [1:0] KIND_TRADE = 2'd0;
   localparam logic [1:0] KIND_BID   = 2'd1;
   localparam logic [1:0] KIND_ASK   = 2'd2;
   localparam logic [1:0] KIND_OTHER = 2'd3;

   localparam logic [1:0] STATUS_MSG     = 2'd0;
   localparam logic [1:0] STATUS_LEN_ERR = 2'd1;
   localparam logic [1:0] STATUS_OFS_ERR = 2'd2;
   localparam logic [1:0] STATUS_SHORT   = 2'd3;

   typedef struct packed {
      logic [7:0]  message_byte;
      logic        message_first;
      logic        message_last;
      logic [1:0]  message_kind;
      logic [63:0] capture_time_ns;
      logic [63:0] segment_send_time;
      logic [1:0]  status;
   } result_type;

   function automatic logic [1:0] classify(input logic [7:0] type_byte);
      logic [1:0] kind;
      case (type_byte)
         CHAR_TRADE: kind = KIND_TRADE;
         CHAR_BID:   kind = KIND_BID;
         CHAR_ASK:   kind = KIND_ASK;
         default:    kind = KIND_OTHER;
      endcase
      return kind;
   endfunction

endpackage

`default_nettype wire

// File: sv/pcap_iex_segment_deframer_top.sv
`default_nettype none

// Channel   Direction  Handshake            Contents
// req_      in         req_valid/req_ready  one capture byte per transaction
// rsp_      out        rsp_valid/rsp_ready  one message byte or error report
// csr_      in         csr_wr_en            max_records, written without wait
//
// A byte is taken every cycle unless a stalled result register holds the parser; the byte
// waits in the input register, and its result, if any, is offered from the result register.
// Throughput is set by the single parse step between the input and result registers.
// Synchronous reset returns the parser to the global header and the limit to 1e9.
// A stalled result register holds the parser, which in turn holds the input register.

module pcap_iex_segment_deframer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_capture_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_message_byte,
   output logic             rsp_message_first,
   output logic             rsp_message_last,
   output logic [1:0]       rsp_message_kind,
   output logic [63:0]      rsp_capture_time_ns,
   output logic [63:0]      rsp_segment_send_time,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);
   import pidf_pkg::*;

   logic       take;
   logic       byte_valid;
   logic [7:0] byte_data;
   logic       slot_free;
   logic       res_valid;
   result_type res;
   result_type rsp;

   pidf_in_reg u_in_reg (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_capture_byte (req_capture_byte),
      .take             (take),
      .byte_valid       (byte_valid),
      .byte_data        (byte_data)
   );

   pidf_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data),
      .slot_free   (slot_free),
      .take        (take),
      .res_valid   (res_valid),
      .res         (res)
   );

   pidf_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_message_byte      = rsp.message_byte;
   assign rsp_message_first     = rsp.message_first;
   assign rsp_message_last      = rsp.message_last;
   assign rsp_message_kind      = rsp.message_kind;
   assign rsp_capture_time_ns   = rsp.capture_time_ns;
   assign rsp_segment_send_time = rsp.segment_send_time;
   assign rsp_status            = rsp.status;

   // Error reports carry no message content.
   a_report_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_MSG |->
         rsp_message_byte == 8'd0 && !rsp_message_first && !rsp_message_last &&
         rsp_message_kind == KIND_TRADE)
      else $error("error report carries message content");

   // The kind on a type byte follows from that byte.
   a_first_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_MSG && rsp_message_first |->
         rsp_message_kind == classify(rsp_message_byte))
      else $error("message kind does not match its type byte");

   // Nothing is offered in the cycle after a reset edge.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

endmodule

`default_nettype wire

// File: sv/pidf_in_reg.sv
`default_nettype none

module pidf_in_reg (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_capture_byte,
   input  wire logic       take,
   output logic            byte_valid,
   output logic [7:0]      byte_data
);
   import pidf_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;

   // The register refills in the same cycle that the parser drains it.
   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_ready) begin
         valid_in = req_valid;
         data_in  = req_capture_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

`default_nettype wire

// File: sv/pidf_parser.sv
`default_nettype none

module pidf_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   input  wire logic        byte_valid,
   input  wire logic [7:0]  byte_data,
   input  wire logic        slot_free,
   output logic             take,
   output logic             res_valid,
   output pidf_pkg::result_type res
);
   import pidf_pkg::*;

   typedef enum logic [2:0] {
      PH_GLOBAL,
      PH_RECHDR,
      PH_LINK,
      PH_SEGHDR,
      PH_MSGLEN,
      PH_BODY,
      PH_SKIP
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [5:0]  pos_ff, pos_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] secs_ff, secs_in;
   logic [31:0] usecs_ff, usecs_in;
   logic [41:0] usec_ns_ff, usec_ns_in;
   logic [63:0] cap_ff, cap_in;
   logic [15:0] paylen_ff, paylen_in;
   logic [15:0] msgs_ff, msgs_in;
   logic [15:0] mbl_ff, mbl_in;
   logic [63:0] send_ff, send_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] seen_ff, seen_in;
   logic [31:0] max_rec_ff, max_rec_in;

   logic        emit;
   logic [1:0]  emit_status;
   logic        emit_body;
   logic        body_first;
   logic        body_last;

   logic [5:0]  pos_inc;
   logic [31:0] rest;
   logic [15:0] mbl_full;
   logic [15:0] msgs_dec;
   logic [15:0] mbl_dec;
   logic        limit_hit;

   assign take      = byte_valid && slot_free;
   assign pos_inc   = pos_ff + 6'd1;
   assign rest      = left_ff - 32'd1;
   assign mbl_full  = {byte_data, mbl_ff[7:0]};
   assign msgs_dec  = msgs_ff - 16'd1;
   assign mbl_dec   = (mbl_ff != 16'd0) ? mbl_ff - 16'd1 : 16'd0;
   assign limit_hit = (max_rec_ff != 32'd0) && (seen_ff >= max_rec_ff);

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      left_in     = left_ff;
      secs_in     = secs_ff;
      usecs_in    = usecs_ff;
      usec_ns_in  = usec_ns_ff;
      cap_in      = cap_ff;
      paylen_in   = paylen_ff;
      msgs_in     = msgs_ff;
      mbl_in      = mbl_ff;
      send_in     = send_ff;
      kind_in     = kind_ff;
      seen_in     = seen_ff;
      max_rec_in  = csr_wr_en ? csr_wr_data : max_rec_ff;
      emit        = 1'b0;
      emit_status = STATUS_MSG;
      emit_body   = 1'b0;
      body_first  = 1'b0;
      body_last   = 1'b0;

      if (take) begin
         unique case (phase_ff)
            PH_GLOBAL: begin
               pos_in = pos_inc;
               if (pos_inc >= GLOBAL_LEN) begin
                  phase_in = PH_RECHDR;
                  pos_in   = 6'd0;
               end
            end
            PH_RECHDR: begin
               // A byte at the head of a record header past the limit is dropped.
               if (!(pos_ff == 6'd0 && limit_hit)) begin
                  // Every lane is overwritten in order, so no clearing is needed.
                  case (pos_ff[3:2])
                     2'd0:    secs_in[8*pos_ff[1:0] +: 8]  = byte_data;
                     2'd1:    usecs_in[8*pos_ff[1:0] +: 8] = byte_data;
                     2'd2:    left_in[8*pos_ff[1:0] +: 8]  = byte_data;
                     default: ;
                  endcase
                  // The capture time is built over three of the trailing header bytes.
                  if (pos_ff == 6'd8) begin
                     cap_in = 64'(secs_ff) * 64'(NS_PER_SEC);
                  end
                  if (pos_ff == 6'd9) begin
                     usec_ns_in = 42'(usecs_ff) * 42'(NS_PER_USEC);
                  end
                  if (pos_ff == 6'd10) begin
                     cap_in = cap_ff + 64'(usec_ns_ff);
                  end
                  pos_in = pos_inc;
                  if (pos_inc == RECHDR_LEN) begin
                     pos_in    = 6'd0;
                     seen_in   = seen_ff + 32'd1;
                     send_in   = 64'd0;
                     paylen_in = 16'd0;
                     msgs_in   = 16'd0;
                     mbl_in    = 16'd0;
                     if (left_ff < 32'(LINK_LEN)) begin
                        phase_in    = (left_ff == 32'd0) ? PH_RECHDR : PH_SKIP;
                        emit        = 1'b1;
                        emit_status = STATUS_SHORT;
                     end else begin
                        phase_in = PH_LINK;
                     end
                  end
               end
            end
            default: begin
               if (left_ff == 32'd0) begin
                  phase_in = PH_RECHDR;
                  pos_in   = 6'd0;
               end else begin
                  left_in = rest;
                  case (phase_ff)
                     PH_LINK: begin
                        pos_in = pos_inc;
                        if (pos_inc == LINK_LEN) begin
                           pos_in = 6'd0;
                           if (rest == 32'd0) begin
                              phase_in    = PH_RECHDR;
                              emit        = 1'b1;
                              emit_status = STATUS_LEN_ERR;
                           end else begin
                              phase_in = PH_SEGHDR;
                           end
                        end
                     end
                     PH_SEGHDR: begin
                        if (pos_ff == 6'd12) paylen_in = {8'd0, byte_data};
                        if (pos_ff == 6'd13) paylen_in = {byte_data, paylen_ff[7:0]};
                        if (pos_ff == 6'd14) msgs_in = {8'd0, byte_data};
                        if (pos_ff == 6'd15) msgs_in = {byte_data, msgs_ff[7:0]};
                        if (pos_ff[5:3] == 3'd4) begin
                           send_in[8*pos_ff[2:0] +: 8] = byte_data;
                        end
                        pos_in = pos_inc;
                        if (pos_inc != SEGHDR_LEN) begin
                           if (rest == 32'd0) begin
                              phase_in    = PH_RECHDR;
                              pos_in      = 6'd0;
                              emit        = 1'b1;
                              emit_status = STATUS_LEN_ERR;
                           end
                        end else if (rest != 32'(paylen_ff)) begin
                           phase_in    = (rest == 32'd0) ? PH_RECHDR : PH_SKIP;
                           pos_in      = 6'd0;
                           emit        = 1'b1;
                           emit_status = STATUS_LEN_ERR;
                        end else if (msgs_ff == 16'd0) begin
                           // Trailing payload with no messages is reported on its first byte.
                           phase_in = (rest == 32'd0) ? PH_RECHDR : PH_SKIP;
                           pos_in   = (rest == 32'd0) ? 6'd0 : 6'd1;
                        end else begin
                           phase_in = PH_MSGLEN;
                           pos_in   = 6'd0;
                        end
                     end
                     PH_MSGLEN: begin
                        if (pos_ff == 6'd0) begin
                           mbl_in = {8'd0, byte_data};
                           pos_in = 6'd1;
                           if (rest == 32'd0) begin
                              phase_in    = PH_RECHDR;
                              pos_in      = 6'd0;
                              emit        = 1'b1;
                              emit_status = STATUS_OFS_ERR;
                           end
                        end else begin
                           mbl_in  = mbl_full;
                           pos_in  = 6'd0;
                           msgs_in = msgs_dec;
                           if (32'(mbl_full) > rest ||
                               (32'(mbl_full) == rest && msgs_dec != 16'd0)) begin
                              phase_in    = (rest == 32'd0) ? PH_RECHDR : PH_SKIP;
                              emit        = 1'b1;
                              emit_status = STATUS_OFS_ERR;
                           end else if (mbl_full == 16'd0) begin
                              if (msgs_dec == 16'd0) begin
                                 phase_in = (rest == 32'd0) ? PH_RECHDR : PH_SKIP;
                                 pos_in   = (rest == 32'd0) ? 6'd0 : 6'd1;
                              end else begin
                                 phase_in = PH_MSGLEN;
                              end
                           end else begin
                              phase_in = PH_BODY;
                           end
                        end
                     end
                     PH_BODY: begin
                        body_first = (pos_ff == 6'd0);
                        if (body_first) kind_in = classify(byte_data);
                        mbl_in    = mbl_dec;
                        body_last = (mbl_dec == 16'd0);
                        pos_in    = 6'd1;
                        emit      = 1'b1;
                        emit_body = 1'b1;
                        if (body_last) begin
                           if (msgs_ff == 16'd0) begin
                              phase_in = (rest == 32'd0) ? PH_RECHDR : PH_SKIP;
                              pos_in   = (rest == 32'd0) ? 6'd0 : 6'd1;
                           end else begin
                              phase_in = PH_MSGLEN;
                              pos_in   = 6'd0;
                           end
                        end
                     end
                     default: begin
                        // Skipping; the first skipped byte may carry a deferred report.
                        pos_in = 6'd0;
                        if (rest == 32'd0) phase_in = PH_RECHDR;
                        if (pos_ff == 6'd1) begin
                           emit        = 1'b1;
                           emit_status = STATUS_OFS_ERR;
                        end
                     end
                  endcase
               end
            end
         endcase
      end
   end

   always_comb begin
      res.message_byte      = emit_body ? byte_data : 8'd0;
      res.message_first     = emit_body && body_first;
      res.message_last      = emit_body && body_last;
      res.message_kind      = emit_body ? kind_in : KIND_TRADE;
      res.capture_time_ns   = cap_in;
      res.segment_send_time = send_in;
      res.status            = emit_status;
   end

   assign res_valid = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_GLOBAL;
         pos_ff     <= 6'd0;
         left_ff    <= 32'd0;
         secs_ff    <= 32'd0;
         usecs_ff   <= 32'd0;
         usec_ns_ff <= 42'd0;
         cap_ff     <= 64'd0;
         paylen_ff  <= 16'd0;
         msgs_ff    <= 16'd0;
         mbl_ff     <= 16'd0;
         send_ff    <= 64'd0;
         kind_ff    <= KIND_OTHER;
         seen_ff    <= 32'd0;
         max_rec_ff <= MAX_RECORDS_INIT;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         left_ff    <= left_in;
         secs_ff    <= secs_in;
         usecs_ff   <= usecs_in;
         usec_ns_ff <= usec_ns_in;
         cap_ff     <= cap_in;
         paylen_ff  <= paylen_in;
         msgs_ff    <= msgs_in;
         mbl_ff     <= mbl_in;
         send_ff    <= send_in;
         kind_ff    <= kind_in;
         seen_ff    <= seen_in;
         max_rec_ff <= max_rec_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/pidf_out_reg.sv
`default_nettype none

module pidf_out_reg (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       res_valid,
   input  wire pidf_pkg::result_type res,
   output logic            slot_free,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output pidf_pkg::result_type rsp
);
   import pidf_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (slot_free) begin
         valid_in = res_valid;
         data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule

`default_nettype wire
